// ----- rtl/core/oqar_pkg.sv -----
package oqar_pkg;

   // Field widths
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default number of queue cells
   localparam int DEPTH_DEFAULT = 16;

   // Operation codes
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_APPENDED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic            append_go;
      logic            remove_go;
      logic [ID_W-1:0] id;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/oqar_if.sv -----
// Request word: operation and task identifier
interface oqar_req_if;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [oqar_pkg::ID_W-1:0] task_id;

   modport source (output valid, output kind, output task_id, input ready);
   modport sink   (input valid, input kind, input task_id, output ready);
endinterface

// Response word: status, count after the operation, echoed identifier
interface oqar_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [oqar_pkg::STATUS_W-1:0] status;
   logic [oqar_pkg::COUNT_W-1:0]  entry_count;
   logic [oqar_pkg::ID_W-1:0]     echo_id;

   modport source (output valid, output status, output entry_count, output echo_id,
                   input ready);
   modport sink   (input valid, input status, input entry_count, input echo_id,
                   output ready);
endinterface

// ----- rtl/core/oqar_cell.sv -----
// One queue slot. Holds an entry, matches it against the command id and
// takes its neighbor's entry when a removal closes the gap.
module oqar_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 5
) (
   input  logic                       clock,
   input  oqar_pkg::cell_ctrl_type    ctrl,
   input  logic [LEN_W-1:0]           length,
   input  logic                       seen_in,
   input  logic [oqar_pkg::ID_W-1:0]  next_entry,
   output logic                       seen_out,
   output logic [oqar_pkg::ID_W-1:0]  entry
);

   logic [oqar_pkg::ID_W-1:0] entry_ff;
   logic [oqar_pkg::ID_W-1:0] entry_in;
   logic                      occupied;
   logic                      is_tail;

   assign occupied = length > LEN_W'(INDEX);
   assign is_tail  = length == LEN_W'(INDEX);

   // first-match chain: high from the matching cell toward the tail
   assign seen_out = seen_in | (occupied & (entry_ff == ctrl.id));

   // append writes the tail slot, removal pulls from the neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append_go && is_tail) begin
         entry_in = ctrl.id;
      end else if (ctrl.remove_go && seen_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/core/ordered_queue_append_remove_unit.sv -----
// Channel   Dir   Words                              Notes
// req_word  in    kind, task_id                      append (0) or remove (1)
// rsp_word  out   status, entry_count, echo_id       one word per request
//
// One request a cycle unless the response stalls; its response appears the
// next cycle from an output register, fed by the combinational match chain
// and one-step shift. Reset clears the count and response valid flag; cell
// contents and response payload are not cleared. A stalled response holds
// the request side only when the response register is full and not taken.
module ordered_queue_append_remove_unit #(
   parameter int QUEUE_DEPTH = oqar_pkg::DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   oqar_req_if.sink       req_word,
   oqar_rsp_if.source     rsp_word
);

   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

   logic [LEN_W-1:0]                length_ff;
   logic [LEN_W-1:0]                length_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [oqar_pkg::STATUS_W-1:0]   status_ff;
   logic [oqar_pkg::STATUS_W-1:0]   status_in;
   logic [oqar_pkg::COUNT_W-1:0]    count_ff;
   logic [oqar_pkg::ID_W-1:0]       echo_ff;

   logic                            accept;
   logic                            full;
   logic                            found;
   oqar_pkg::cell_ctrl_type         ctrl;
   logic [QUEUE_DEPTH:0]            seen;
   logic [oqar_pkg::ID_W-1:0]       entry [QUEUE_DEPTH];
   logic [oqar_pkg::ID_W-1:0]       next_entry [QUEUE_DEPTH];

   // handshake: accept whenever the response slot is free or draining
   assign req_word.ready = !rsp_valid_ff || rsp_word.ready;
   assign accept         = req_word.valid && req_word.ready;
   assign full           = length_ff == LEN_W'(QUEUE_DEPTH);
   assign found          = seen[QUEUE_DEPTH];

   assign ctrl.append_go = accept && (req_word.kind == oqar_pkg::KIND_APPEND) && !full;
   assign ctrl.remove_go = accept && (req_word.kind == oqar_pkg::KIND_REMOVE);
   assign ctrl.id        = req_word.task_id;

   // row of cells, head at index 0
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_entry[i] = entry[i];
      end else begin : g_mid
         assign next_entry[i] = entry[i+1];
      end
      oqar_cell #(
         .INDEX (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .length     (length_ff),
         .seen_in    (seen[i]),
         .next_entry (next_entry[i]),
         .seen_out   (seen[i+1]),
         .entry      (entry[i])
      );
   end

   // count and status
   always_comb begin
      length_in = length_ff;
      status_in = oqar_pkg::ST_APPENDED;
      if (req_word.kind == oqar_pkg::KIND_APPEND) begin
         if (full) begin
            status_in = oqar_pkg::ST_FULL;
         end else begin
            status_in = oqar_pkg::ST_APPENDED;
            length_in = length_ff + LEN_W'(1);
         end
      end else begin
         if (found) begin
            status_in = oqar_pkg::ST_REMOVED;
            length_in = length_ff - LEN_W'(1);
         end else begin
            status_in = oqar_pkg::ST_NOT_FOUND;
         end
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_word.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            length_ff <= length_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         count_ff  <= oqar_pkg::COUNT_W'(length_in);
         echo_ff   <= req_word.task_id;
      end
   end

   assign rsp_word.valid       = rsp_valid_ff;
   assign rsp_word.status      = status_ff;
   assign rsp_word.entry_count = count_ff;
   assign rsp_word.echo_id     = echo_ff;

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (ctrl.remove_go && found) |=> (length_ff == $past(length_ff) - LEN_W'(1)))
      else $error("successful removal did not shrink the queue");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.kind == oqar_pkg::KIND_APPEND && full)
      |=> (rsp_word.status == oqar_pkg::ST_FULL && $stable(length_ff)))
      else $error("append to full queue not dropped");

   a_miss_holds: assert property (@(posedge clock) disable iff (reset)
      (ctrl.remove_go && !found)
      |=> (rsp_word.status == oqar_pkg::ST_NOT_FOUND && $stable(length_ff)))
      else $error("missed removal changed the queue");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_word.ready |-> rsp_valid_ff)
      else $error("request stalled with empty response slot");

endmodule
